@@ design/des_pkg.sv @@
// Shared widths, result codes and word types for the deferred event scheduler.
package des_pkg;

   localparam int TICK_BITS = 32;
   localparam int TAG_BITS  = 16;
   localparam int IDX_BITS  = 6;

   // operation codes
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_REG_ABS  = 2'd1;
   localparam logic [1:0] OP_REG_REL  = 2'd2;
   localparam logic [1:0] OP_REMOVE   = 2'd3;

   // result kinds
   localparam logic [1:0] KIND_FIRED   = 2'd0;
   localparam logic [1:0] KIND_GRANT   = 2'd1;
   localparam logic [1:0] KIND_REMOVED = 2'd2;
   localparam logic [1:0] KIND_DONE    = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_PAST  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [1:0]           pad;
      logic [IDX_BITS-1:0]  handle_index;
      logic [TAG_BITS-1:0]  tag;
      logic [TICK_BITS-1:0] tick_value;
   } req_data_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]  event_tag;
      logic [IDX_BITS-1:0]  slot_index;
      logic [TICK_BITS-1:0] due_tick;
      logic [1:0]           status;
   } rsp_data_type;

endpackage

@@ design/deferred_event_scheduler.sv @@
// Top level of the deferred event scheduler: sequencer, pool flags and result register.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser operation, tdata tick/tag/index
//  rsp     | out | rsp_tvalid/tready    | tuser kind, tlast last, tdata status/due/slot/tag
//
// A tick, a register or a nonzero-index remove walks the pool through the shared
// compare unit, each entry by a memory read and then a compare.
// A tick then reads the order map for each held entry for its tick and ends with the done word.
// Registers rejected as past and empty-handle removes skip the walk and go straight to the result word.
// Reset clears the pool flags, last tick and the result valid flag; no clearing pass.
// A stalled result word holds the sequencer; a new request is taken once the last word
// of the previous one sits in the result register.
module deferred_event_scheduler #(
   parameter int POOL_ENTRIES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] operation
   input  logic [1:0]                        req_tuser,
   // [31:0] tick_value, [47:32] tag, [53:48] handle_index, [55:54] zero
   input  logic [$bits(des_pkg::req_data_type)-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] kind
   output logic [1:0]                        rsp_tuser,
   output logic                              rsp_tlast,
   // [1:0] status, [33:2] due_tick, [39:34] slot_index, [55:40] event_tag
   output logic [$bits(des_pkg::rsp_data_type)-1:0] rsp_tdata
);
   import des_pkg::*;

   localparam int SLOT_W  = $clog2(POOL_ENTRIES);
   localparam int ORD_W   = $clog2(POOL_ENTRIES + 1);
   localparam int ENT_W   = TICK_BITS + ORD_W + TAG_BITS;
   localparam int MAP_W   = 1 + TAG_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EV   = 3'd2;
   localparam logic [2:0] S_REG  = 3'd3;
   localparam logic [2:0] S_PUSH = 3'd4;
   localparam logic [2:0] S_ERD  = 3'd5;
   localparam logic [2:0] S_EOUT = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   req_data_type req_word;
   rsp_data_type rsp_word_ff, rsp_word_in;

   logic [2:0]              state_ff, state_in;
   logic [SLOT_W-1:0]       scan_ff, scan_in;
   logic [ORD_W-1:0]        cnt_ff, cnt_in;
   logic [ORD_W-1:0]        emit_ff, emit_in;
   logic [SLOT_W-1:0]       free_ff, free_in;
   logic                    found_ff, found_in;
   logic [1:0]              op_ff, op_in;
   logic [TICK_BITS-1:0]    key_ff, key_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   logic [IDX_BITS-1:0]     idx_ff, idx_in;
   logic [1:0]              stat_ff, stat_in;
   logic [TICK_BITS-1:0]    last_tick_ff, last_tick_in;
   logic [POOL_ENTRIES-1:0] valid_ff, valid_in;
   logic [POOL_ENTRIES-1:0] cancel_ff, cancel_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    ent_we, map_we;
   logic [SLOT_W-1:0]       ent_waddr, ent_raddr, map_waddr, map_raddr;
   logic [ENT_W-1:0]        ent_wdata, ent_rdata;
   logic [MAP_W-1:0]        map_wdata, map_rdata;

   logic [TICK_BITS-1:0]    rd_due;
   logic [ORD_W-1:0]        rd_ord;
   logic [TAG_BITS-1:0]     rd_tag;
   logic                    match;
   logic                    can_push, push, accept;
   logic [TICK_BITS:0]      rel_sum;
   logic [ORD_W-1:0]        new_ord;

   assign req_word  = req_data_type'(req_tdata);
   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign can_push  = !rsp_valid_ff || rsp_tready;

   assign {rd_due, rd_ord, rd_tag} = ent_rdata;
   assign match   = valid_ff[scan_ff] && (rd_due == key_ff);
   assign rel_sum = {1'b0, last_tick_ff} + {1'b0, req_word.tick_value};
   assign new_ord = cnt_ff + ORD_W'(1);

   // entry store: due tick, order and tag per slot
   des_ram #(.WIDTH(ENT_W), .DEPTH(POOL_ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   // order map: live flag and tag by order for the tick being fired
   des_ram #(.WIDTH(MAP_W), .DEPTH(POOL_ENTRIES)) u_order_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   assign ent_raddr = scan_ff;
   assign ent_waddr = free_ff;
   assign ent_wdata = {key_ff, new_ord, tag_ff};
   assign map_raddr = emit_ff[SLOT_W-1:0];
   assign map_waddr = SLOT_W'(rd_ord - ORD_W'(1));
   assign map_wdata = {!cancel_ff[scan_ff], rd_tag};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      cnt_in       = cnt_ff;
      emit_in      = emit_ff;
      free_in      = free_ff;
      found_in     = found_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      tag_in       = tag_ff;
      idx_in       = idx_ff;
      stat_in      = stat_ff;
      last_tick_in = last_tick_ff;
      valid_in     = valid_ff;
      cancel_in    = cancel_ff;
      ent_we       = 1'b0;
      map_we       = 1'b0;
      push         = 1'b0;
      rsp_kind_in  = KIND_DONE;
      rsp_last_in  = 1'b1;
      rsp_word_in  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_tuser;
               key_in   = req_word.tick_value;
               tag_in   = req_word.tag;
               idx_in   = req_word.handle_index;
               stat_in  = ST_OK;
               scan_in  = '0;
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_RD;
               unique case (req_tuser)
                  OP_TICK: begin
                     last_tick_in = req_word.tick_value;
                  end
                  OP_REG_ABS: begin
                     if (req_word.tick_value <= last_tick_ff) begin
                        stat_in  = ST_PAST;
                        state_in = S_PUSH;
                     end
                  end
                  OP_REG_REL: begin
                     key_in = rel_sum[TICK_BITS-1:0];
                     if (req_word.tick_value == '0 || rel_sum[TICK_BITS]) begin
                        stat_in  = ST_PAST;
                        state_in = S_PUSH;
                     end
                  end
                  default: begin
                     if (req_word.handle_index == '0) begin
                        state_in = S_PUSH;
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            state_in = S_EV;
         end
         S_EV: begin
            if (match) begin
               cnt_in = cnt_ff + ORD_W'(1);
            end
            if (!valid_ff[scan_ff] && !found_ff) begin
               free_in  = scan_ff;
               found_in = 1'b1;
            end
            if (op_ff == OP_TICK && match) begin
               map_we             = 1'b1;
               valid_in[scan_ff]  = 1'b0;
               cancel_in[scan_ff] = 1'b0;
            end
            if (op_ff == OP_REMOVE && match && IDX_BITS'(rd_ord) == idx_ff) begin
               cancel_in[scan_ff] = 1'b1;
            end
            if (scan_ff == SLOT_W'(POOL_ENTRIES - 1)) begin
               unique case (op_ff)
                  OP_TICK: begin
                     emit_in  = '0;
                     state_in = (cnt_in == '0) ? S_DONE : S_ERD;
                  end
                  OP_REMOVE: begin
                     if (cnt_in != '0 && idx_ff > IDX_BITS'(cnt_in)) begin
                        stat_in = ST_RANGE;
                     end
                     state_in = S_PUSH;
                  end
                  default: begin
                     if (found_in) begin
                        state_in = S_REG;
                     end else begin
                        stat_in  = ST_FULL;
                        state_in = S_PUSH;
                     end
                  end
               endcase
            end else begin
               scan_in  = scan_ff + SLOT_W'(1);
               state_in = S_RD;
            end
         end
         S_REG: begin
            rsp_kind_in            = KIND_GRANT;
            rsp_word_in.status     = ST_OK;
            rsp_word_in.due_tick   = key_ff;
            rsp_word_in.slot_index = IDX_BITS'(new_ord);
            if (can_push) begin
               push               = 1'b1;
               ent_we             = 1'b1;
               valid_in[free_ff]  = 1'b1;
               cancel_in[free_ff] = 1'b0;
               state_in           = S_IDLE;
            end
         end
         S_PUSH: begin
            rsp_kind_in        = (op_ff == OP_REMOVE) ? KIND_REMOVED : KIND_GRANT;
            rsp_word_in.status = stat_ff;
            if (can_push) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            rsp_kind_in            = KIND_FIRED;
            rsp_last_in            = 1'b0;
            rsp_word_in.due_tick   = key_ff;
            rsp_word_in.slot_index = IDX_BITS'(emit_ff + ORD_W'(1));
            rsp_word_in.event_tag  = map_rdata[TAG_BITS-1:0];
            if (!map_rdata[MAP_W-1] || can_push) begin
               push = map_rdata[MAP_W-1];
               if (emit_ff + ORD_W'(1) == cnt_ff) begin
                  state_in = S_DONE;
               end else begin
                  emit_in  = emit_ff + ORD_W'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            rsp_kind_in          = KIND_DONE;
            rsp_word_in.due_tick = key_ff;
            if (can_push) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase

      // hold or drop the result word
      rsp_valid_in = push ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_tick_ff <= '0;
         valid_ff     <= '0;
         cancel_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_tick_ff <= last_tick_in;
         valid_ff     <= valid_in;
         cancel_ff    <= cancel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      cnt_ff   <= cnt_in;
      emit_ff  <= emit_in;
      free_ff  <= free_in;
      found_ff <= found_in;
      op_ff    <= op_in;
      key_ff   <= key_in;
      tag_ff   <= tag_in;
      idx_ff   <= idx_in;
      stat_ff  <= stat_in;
      if (push) begin
         rsp_word_ff <= rsp_word_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = rsp_word_ff;

   // a fired event is always followed by the done word, so the sequencer is busy
   a_fired_not_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> state_ff != S_IDLE)
      else $error("fired word pending while sequencer idle");

   // held count never exceeds the pool while a word is being worked on
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> cnt_ff <= ORD_W'(POOL_ENTRIES))
      else $error("entry count beyond pool size");

   // a fired word never carries last and always has status OK
   a_fired_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_FIRED |-> !rsp_tlast && rsp_tdata[1:0] == ST_OK)
      else $error("fired word malformed");

   // an accepted request makes the block busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while busy");

endmodule

@@ design/des_ram.sv @@
// Simple dual-port memory with one write port and one registered read port.
module des_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/sv/deferred_event_scheduler_tb.sv @@
// Self-checking testbench for the deferred event scheduler stream block.
`timescale 1ns / 100ps

module deferred_event_scheduler_tb;
   import des_pkg::*;

   localparam int POOL = 32;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [31:0] due_tick;
      logic [5:0]  slot_index;
      logic [15:0] event_tag;
      logic        last;
   } sched_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [$bits(req_data_type)-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic [$bits(rsp_data_type)-1:0] rsp_tdata;

   // predictor state
   logic [31:0] pool_last_tick;
   logic        pool_valid [POOL];
   logic        pool_cancelled [POOL];
   logic [31:0] pool_due [POOL];
   logic [5:0]  pool_order [POOL];
   logic [15:0] pool_tag [POOL];

   sched_result_t pending_results[$];
   int mismatch_count = 0;
   int stray_count = 0;
   int words_sent = 0;
   int words_checked = 0;
   int idle_cycles = 0;
   bit timed_out = 1'b0;
   bit allow_stall = 1'b1;

   deferred_event_scheduler uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Count entries held for one due tick, cancelled ones included.
   function automatic int held_for(logic [31:0] due);
      int n;
      n = 0;
      for (int i = 0; i < POOL; i++)
         if (pool_valid[i] && pool_due[i] == due) n++;
      return n;
   endfunction

   function automatic sched_result_t make_result(logic [1:0] kind, logic [1:0] status,
         logic [31:0] due, logic [5:0] slot, logic [15:0] tag, logic last);
      sched_result_t r;
      r.kind = kind; r.status = status; r.due_tick = due;
      r.slot_index = slot; r.event_tag = tag; r.last = last;
      return r;
   endfunction

   // Advance the pool model by one word and queue the results it causes.
   task automatic predict_word(logic [1:0] op, logic [31:0] tv, logic [15:0] tag,
         logic [5:0] idx);
      logic [31:0] due;
      logic [32:0] sum;
      bit ok;
      int slot;
      int n;
      case (op)
         OP_TICK: begin
            pool_last_tick = tv;
            for (int ord = 1; ord <= POOL; ord++)
               for (int i = 0; i < POOL; i++)
                  if (pool_valid[i] && pool_due[i] == tv && pool_order[i] == ord
                        && !pool_cancelled[i])
                     pending_results.push_back(make_result(KIND_FIRED, ST_OK, tv,
                        6'(ord), pool_tag[i], 1'b0));
            for (int i = 0; i < POOL; i++)
               if (pool_valid[i] && pool_due[i] == tv) begin
                  pool_valid[i] = 1'b0;
                  pool_cancelled[i] = 1'b0;
               end
            pending_results.push_back(make_result(KIND_DONE, ST_OK, tv, 0, 0, 1'b1));
         end
         OP_REG_ABS, OP_REG_REL: begin
            if (op == OP_REG_ABS) begin
               due = tv;
               ok = tv > pool_last_tick;
            end else begin
               sum = {1'b0, pool_last_tick} + {1'b0, tv};
               due = sum[31:0];
               ok = tv != 0 && !sum[32];
            end
            slot = -1;
            for (int i = POOL - 1; i >= 0; i--)
               if (!pool_valid[i]) slot = i;
            if (!ok)
               pending_results.push_back(make_result(KIND_GRANT, ST_PAST, 0, 0, 0, 1'b1));
            else if (slot < 0)
               pending_results.push_back(make_result(KIND_GRANT, ST_FULL, 0, 0, 0, 1'b1));
            else begin
               n = held_for(due) + 1;
               pool_valid[slot] = 1'b1;
               pool_cancelled[slot] = 1'b0;
               pool_due[slot] = due;
               pool_order[slot] = 6'(n);
               pool_tag[slot] = tag;
               pending_results.push_back(make_result(KIND_GRANT, ST_OK, due, 6'(n), 0,
                  1'b1));
            end
         end
         default: begin
            logic [1:0] st;
            st = ST_OK;
            if (idx != 0) begin
               n = held_for(tv);
               if (n != 0) begin
                  if (idx > n) st = ST_RANGE;
                  else
                     for (int i = 0; i < POOL; i++)
                        if (pool_valid[i] && pool_due[i] == tv && pool_order[i] == idx)
                           pool_cancelled[i] = 1'b1;
               end
            end
            pending_results.push_back(make_result(KIND_REMOVED, st, 0, 0, 0, 1'b1));
         end
      endcase
   endtask

   // Send one word after a random gap, predicting at acceptance.
   // Valid stays high after acceptance; a gap before the next word or an explicit drop lowers it.
   task automatic send_word(logic [1:0] op, logic [31:0] tv, logic [15:0] tag,
         logic [5:0] idx);
      req_data_type d;
      int gap;
      gap = allow_stall ? $urandom_range(0, 12) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      d.pad = '0; d.handle_index = idx; d.tag = tag; d.tick_value = tv;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      predict_word(op, tv, tag, idx);
      words_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && !timed_out) @(posedge clock);
      repeat (4 * POOL + 20) @(posedge clock);
   endtask

   // Check each accepted result word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sched_result_t got, want;
         rsp_data_type d;
         d = rsp_tdata;
         got = make_result(rsp_tuser, d.status, d.due_tick, d.slot_index, d.event_tag,
            rsp_tlast);
         words_checked++;
         if (pending_results.size() == 0) begin
            stray_count++;
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result word kind=%0d due=%0d", got.kind, got.due_tick);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp kind=%0d st=%0d due=%0d slot=%0d tag=%0d last=%0d",
                     want.kind, want.status, want.due_tick, want.slot_index,
                     want.event_tag, want.last, " | got kind=%0d st=%0d due=%0d ",
                     got.kind, got.status, got.due_tick,
                     "slot=%0d tag=%0d last=%0d", got.slot_index, got.event_tag, got.last);
            end
         end
      end
   end

   // Draw a stall length per result word on the receive side.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = allow_stall && $urandom_range(0, 2) != 0 ? $urandom_range(0, 12) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // End the run when nothing is accepted for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog: no handshake in %0d cycles", WATCHDOG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Field extremes, every operation and the remove corner cases.
   task automatic test_directed();
      send_word(OP_REG_ABS, 32'd0, 16'hFFFF, 6'd0);         // not in future
      send_word(OP_REG_REL, 32'd0, 16'h1234, 6'd0);         // zero delay
      send_word(OP_REG_ABS, 32'd100, 16'hFFFF, 6'd63);
      send_word(OP_REG_ABS, 32'd100, 16'h0000, 6'd0);
      send_word(OP_REG_REL, 32'd100, 16'hA5A5, 6'd0);
      send_word(OP_REMOVE, 32'd100, 16'hFFFF, 6'd0);        // empty handle
      send_word(OP_REMOVE, 32'd555, 16'd0, 6'd1);           // unknown tick
      send_word(OP_REMOVE, 32'd100, 16'd0, 6'd63);          // out of range
      send_word(OP_REMOVE, 32'd100, 16'd0, 6'd2);
      send_word(OP_REMOVE, 32'd100, 16'd0, 6'd2);           // already cancelled
      send_word(OP_TICK, 32'd100, 16'hFFFF, 6'd63);
      send_word(OP_TICK, 32'd50, 16'd0, 6'd0);              // backward tick
      send_word(OP_REG_ABS, 32'hFFFF_FFFF, 16'h5A5A, 6'd0);
      send_word(OP_REG_REL, 32'hFFFF_FFFF, 16'd1, 6'd0);    // overflow
      send_word(OP_REG_REL, 32'hFFFF_FFCD, 16'd2, 6'd0);    // lands on the max tick
      send_word(OP_REMOVE, 32'hFFFF_FFFF, 16'd0, 6'd1);
      send_word(OP_TICK, 32'hFFFF_FFFF, 16'd0, 6'd0);
      send_word(OP_TICK, 32'd0, 16'd0, 6'd0);
   endtask

   // Fill the pool past capacity, then drain it.
   task automatic test_pool_full();
      for (int i = 0; i < POOL + 2; i++)
         send_word(OP_REG_ABS, 32'd10 + (i % 3), 16'($urandom), 6'd0);
      send_word(OP_REMOVE, 32'd10, 16'd0, 6'd12);
      for (int t = 10; t < 13; t++) send_word(OP_TICK, 32'(t), 16'd0, 6'd0);
   endtask

   // Random traffic, mostly register/remove/tick cycles on a small tick window.
   task automatic test_random(int count);
      logic [31:0] base;
      int op_pick;
      base = 32'd20;
      for (int n = 0; n < count; n++) begin
         op_pick = $urandom_range(0, 99);
         if (op_pick < 45)
            send_word(OP_REG_ABS, base + $urandom_range(0, 5), 16'($urandom),
               6'($urandom));
         else if (op_pick < 60)
            send_word(OP_REG_REL, $urandom_range(0, 4) == 0 ? $urandom :
               32'($urandom_range(0, 5)), 16'($urandom), 6'($urandom));
         else if (op_pick < 80)
            send_word(OP_REMOVE, base + $urandom_range(0, 5), 16'($urandom),
               6'($urandom_range(0, 9)));
         else if (op_pick < 97) begin
            base = base + $urandom_range(0, 2);
            send_word(OP_TICK, base, 16'($urandom), 6'($urandom));
         end else
            send_word(2'($urandom_range(0, 3)), $urandom, 16'($urandom), 6'($urandom));
         if (n == count / 2) begin
            // hold off until the scheduler has flushed everything
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
            allow_stall = 1'b0;
         end
         if (n == count / 2 + 30) allow_stall = 1'b1;
      end
   endtask

   initial begin
      pool_last_tick = '0;
      for (int i = 0; i < POOL; i++) begin
         pool_valid[i] = 1'b0;
         pool_cancelled[i] = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pool_full();
      test_random(215);
      wait_drained();
      $display("sent %0d request words, checked %0d result words, %0d unexpected",
         words_sent, words_checked, stray_count);
      $display("covered all operations, pool overflow, cancels and tick wraps");
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
